### hw/rtl/dmwbc_pkg.sv
// Shared types and constants for the direct-mapped write-back cache.
package dmwbc_pkg;

	// Width of one stored byte
	localparam int BYTE_W = 8;

	// Access codes on the operation field
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_FILL
	} state_t;

endpackage

### hw/rtl/dmwbc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module dmwbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, old data on a same-address collision
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/direct_mapped_writeback_cache_unit.sv
// Top level of the direct-mapped write-back, write-allocate byte cache.
//
//  channel   direction  handshake             payload
//  ------------------------------------------------------------------------
//  request   in         in_valid / in_ready    address, operation, write_data
//  response  out        out_valid / out_ready  read_data, hit, was_dirty
//
// A hit is handled in the lookup stage, and a new beat may enter every cycle
// while hits go on and the response register is free (or the access is a
// write); the response register loads at the end of the lookup step.
// A miss takes the line-store read in the lookup step, where a dirty victim
// is written back, then the backing line read in the fill step, an order set
// by the registered read of the two RAMs. Writes produce no response.
// After reset a clearing pass zeroes both RAMs; in_ready is low meanwhile.
// A read whose response register is still full holds in its last step.
module direct_mapped_writeback_cache_unit #(
	parameter int BYTES_PER_LINE = 8,
	parameter int LINE_COUNT     = 32,
	parameter int ADDRESS_BITS   = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [ADDRESS_BITS-1:0] address,
	input  logic                    operation,
	input  logic [7:0]              write_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [7:0]              read_data,
	output logic                    hit,
	output logic                    was_dirty
);

	import dmwbc_pkg::*;

	localparam int OFF_W     = $clog2(BYTES_PER_LINE);
	localparam int IDX_W     = $clog2(LINE_COUNT);
	localparam int TAG_RAW   = ADDRESS_BITS - OFF_W - IDX_W;
	localparam int TAG_W     = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int EXT_W     = OFF_W + IDX_W + TAG_W;
	localparam int LINE_AW   = ADDRESS_BITS - OFF_W;
	localparam int MEM_LINES = 2 ** LINE_AW;
	localparam int LINE_W    = BYTES_PER_LINE * BYTE_W;
	localparam int WORD_W    = TAG_W + 1 + LINE_W;
	localparam int CLR_LINES = (MEM_LINES > LINE_COUNT) ? MEM_LINES : LINE_COUNT;
	localparam int CLR_W     = $clog2(CLR_LINES);

	typedef logic [BYTES_PER_LINE-1:0][BYTE_W-1:0] line_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             dirty;
		line_t            bytes;
	} cword_t;

	// Control state
	state_t           state_q, state_d;
	logic [CLR_W-1:0] clr_q;
	logic             fwd_v_q;
	logic             out_valid_q;

	// Payload registers
	logic [ADDRESS_BITS-1:0] addr_q;
	logic                    op_q;
	logic [BYTE_W-1:0]       wdata_q;
	logic                    vdirty_q;
	logic [IDX_W-1:0]        fwd_idx_q;
	cword_t                  fwd_word_q;
	logic [BYTE_W-1:0]       read_data_q;
	logic                    hit_q;
	logic                    was_dirty_q;

	// Address fields of the incoming and the current access
	logic [EXT_W-1:0]   in_ext, cur_ext;
	logic [IDX_W-1:0]   in_idx, idx_cur;
	logic [OFF_W-1:0]   off_cur;
	logic [TAG_W-1:0]   tag_cur;
	logic [LINE_AW-1:0] fill_line;

	// RAM ports
	logic               cache_we;
	logic [IDX_W-1:0]   cache_waddr, cache_raddr;
	cword_t             cache_wdata;
	logic [WORD_W-1:0]  cache_rdata;
	logic               mem_we;
	logic [LINE_AW-1:0] mem_waddr;
	line_t              mem_wdata;
	logic [LINE_W-1:0]  mem_rdata;

	// Step control
	cword_t            cur_word;
	logic              tag_match;
	logic              out_free;
	logic              is_wr;
	logic              done;
	logic              in_fire;
	logic              res_load;
	logic [BYTE_W-1:0] res_data;
	logic              res_hit;
	logic              res_dirty;

	assign in_ext    = EXT_W'(address);
	assign in_idx    = in_ext[OFF_W +: IDX_W];
	assign cur_ext   = EXT_W'(addr_q);
	assign idx_cur   = cur_ext[OFF_W +: IDX_W];
	assign off_cur   = cur_ext[OFF_W-1:0];
	assign tag_cur   = cur_ext[EXT_W-1 -: TAG_W];
	assign fill_line = addr_q[ADDRESS_BITS-1:OFF_W];

	// Forward the line written last cycle over the stale RAM read
	assign cur_word  = (fwd_v_q && fwd_idx_q == idx_cur) ? fwd_word_q : cword_t'(cache_rdata);
	assign tag_match = cur_word.tag == tag_cur;
	assign out_free  = !out_valid_q || out_ready;
	assign is_wr     = op_q == OP_WRITE;
	assign in_ready  = (state_q == ST_IDLE) || done;
	assign in_fire   = in_valid && in_ready;

	assign cache_raddr = in_fire ? in_idx : idx_cur;

	// Next state, RAM writes and response load
	always_comb begin
		line_t hit_mod;
		line_t fill_mod;

		hit_mod  = cur_word.bytes;
		hit_mod[off_cur] = wdata_q;
		fill_mod = line_t'(mem_rdata);
		if (is_wr) begin
			fill_mod[off_cur] = wdata_q;
		end

		state_d     = state_q;
		done        = 1'b0;
		cache_we    = 1'b0;
		cache_waddr = idx_cur;
		cache_wdata = '0;
		mem_we      = 1'b0;
		mem_waddr   = fill_line;
		mem_wdata   = '0;
		res_load    = 1'b0;
		res_data    = '0;
		res_hit     = 1'b0;
		res_dirty   = 1'b0;

		unique case (state_q)
			ST_CLEAR: begin
				cache_we    = 1'b1;
				cache_waddr = clr_q[IDX_W-1:0];
				mem_we      = 1'b1;
				mem_waddr   = clr_q[LINE_AW-1:0];
				if (clr_q == CLR_W'(CLR_LINES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (tag_match) begin
					if (is_wr) begin
						done              = 1'b1;
						cache_we          = 1'b1;
						cache_wdata.tag   = tag_cur;
						cache_wdata.dirty = 1'b1;
						cache_wdata.bytes = hit_mod;
					end else if (out_free) begin
						done      = 1'b1;
						res_load  = 1'b1;
						res_data  = cur_word.bytes[off_cur];
						res_hit   = 1'b1;
						res_dirty = cur_word.dirty;
					end
					if (done && !in_fire) begin
						state_d = ST_IDLE;
					end
				end else begin
					// Write back a dirty victim; the fill read is already out
					mem_we    = cur_word.dirty;
					mem_waddr = LINE_AW'({cur_word.tag, idx_cur});
					mem_wdata = cur_word.bytes;
					state_d   = ST_FILL;
				end
			end
			ST_FILL: begin
				if (is_wr || out_free) begin
					done              = 1'b1;
					cache_we          = 1'b1;
					cache_wdata.tag   = tag_cur;
					cache_wdata.dirty = is_wr;
					cache_wdata.bytes = fill_mod;
					if (!is_wr) begin
						res_load  = 1'b1;
						res_data  = fill_mod[off_cur];
						res_dirty = vdirty_q;
					end
					state_d = in_fire ? ST_LOOKUP : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			fwd_v_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CLR_W'(1);
			end
			fwd_v_q <= cache_we && (state_q != ST_CLEAR);
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			addr_q  <= address;
			op_q    <= operation;
			wdata_q <= write_data;
		end
		if (state_q == ST_LOOKUP) begin
			vdirty_q <= cur_word.dirty;
		end
		fwd_idx_q  <= cache_waddr;
		fwd_word_q <= cache_wdata;
		if (res_load) begin
			read_data_q <= res_data;
			hit_q       <= res_hit;
			was_dirty_q <= res_dirty;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign hit       = hit_q;
	assign was_dirty = was_dirty_q;

	// Tag, dirty bit and bytes of each cache line
	dmwbc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(LINE_COUNT)
	) u_line_ram (
		.clk  (clk),
		.we   (cache_we),
		.waddr(cache_waddr),
		.wdata(cache_wdata),
		.raddr(cache_raddr),
		.rdata(cache_rdata)
	);

	// Backing memory, one line per word
	dmwbc_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MEM_LINES)
	) u_back_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(fill_line),
		.rdata(mem_rdata)
	);

endmodule

### hw/rtl/dmwbc_checker.sv
// Port-level assertions for the cache top level, and their bind.
module dmwbc_checker #(
	parameter int ADDRESS_BITS = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic [ADDRESS_BITS-1:0] address,
	input logic                    operation,
	input logic [7:0]              write_data,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [7:0]              read_data,
	input logic                    hit,
	input logic                    was_dirty
);

	import dmwbc_pkg::*;

	logic in_beat;

	assign in_beat = in_valid && in_ready;

	// Hold a stalled response beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(hit)
			&& $stable(was_dirty))
		else $error("response beat changed while stalled");

	// A fresh response must stem from an earlier read beat, on the hit or the miss path
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(in_beat, 2) && $past(operation, 2) == OP_READ)
			|| ($past(in_beat, 3) && $past(operation, 3) == OP_READ))
		else $error("response beat without a matching read");

	// No request taken in the first cycle after reset: the clearing pass runs
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_ready && !out_valid)
		else $error("request or response during clearing pass");

	// Hold a waiting request beat
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(address) && $stable(operation)
			&& $stable(write_data))
		else $error("request beat changed while waiting");

endmodule

bind direct_mapped_writeback_cache_unit dmwbc_checker #(
	.ADDRESS_BITS(ADDRESS_BITS)
) u_dmwbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.address   (address),
	.operation (operation),
	.write_data(write_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.read_data (read_data),
	.hit       (hit),
	.was_dirty (was_dirty)
);
